>>> hdl/ltc_pkg.sv
// Package for the leading tag classifier: transaction types, class codes and the
// fixed glyph and word patterns. No dependencies; used by every module in hdl.
package ltc_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [2:0] class_code;
        logic       settled;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

    localparam logic [2:0] CLS_IN_PROGRESS = 3'd0;
    localparam logic [2:0] CLS_EXECUTING   = 3'd1;
    localparam logic [2:0] CLS_VERDICT     = 3'd2;
    localparam logic [2:0] CLS_HAZARD      = 3'd3;
    localparam logic [2:0] CLS_BLOCKED     = 3'd4;

    localparam int NUM_GLYPHS = 5;
    localparam int NUM_WORDS  = 7;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_OPEN    = 8'h5B;
    localparam logic [7:0] CH_CLOSE   = 8'h5D;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_THREE = 8'hE2;

    // Candidate sets loaded by the lead byte of a glyph.
    localparam logic [NUM_GLYPHS-1:0] GLYPHS_FOUR  = 5'b00011;
    localparam logic [NUM_GLYPHS-1:0] GLYPHS_THREE = 5'b11100;

    // Glyph bytes, first byte in the top bits, unused bytes zero.
    localparam logic [31:0] GLYPH_TEXT [NUM_GLYPHS] = '{
        32'hF09F8F81, 32'hF09F948D, 32'hE296B600, 32'hE29AA000, 32'hE29D9300
    };
    localparam logic [3:0] GLYPH_LEN [NUM_GLYPHS] = '{4'd4, 4'd4, 4'd3, 4'd3, 4'd3};
    localparam logic [2:0] GLYPH_CLASS [NUM_GLYPHS] = '{
        CLS_VERDICT, CLS_IN_PROGRESS, CLS_EXECUTING, CLS_HAZARD, CLS_BLOCKED
    };

    // Words padded to nine characters, first character in the top bits.
    localparam logic [71:0] WORD_TEXT [NUM_WORDS] = '{
        "verdict  ", "done     ", "hazard   ", "warning  ",
        "executing", "exec     ", "blocked  "
    };
    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd7, 4'd4, 4'd6, 4'd7, 4'd9, 4'd4, 4'd7
    };
    localparam logic [2:0] WORD_CLASS [NUM_WORDS] = '{
        CLS_VERDICT, CLS_VERDICT, CLS_HAZARD, CLS_HAZARD,
        CLS_EXECUTING, CLS_EXECUTING, CLS_BLOCKED
    };

    function automatic logic [7:0] glyph_char(input logic [31:0] text, input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = text[31:24];
            4'd1:    ch = text[23:16];
            4'd2:    ch = text[15:8];
            4'd3:    ch = text[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] word_char(input logic [71:0] text, input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = text[71:64];
            4'd1:    ch = text[63:56];
            4'd2:    ch = text[55:48];
            4'd3:    ch = text[47:40];
            4'd4:    ch = text[39:32];
            4'd5:    ch = text[31:24];
            4'd6:    ch = text[23:16];
            4'd7:    ch = text[15:8];
            4'd8:    ch = text[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;
    endfunction

endpackage

>>> hdl/ltc_core.sv
// Per-byte matcher of the leading tag classifier: holds the message state and
// decides the class of a message. Depends on ltc_pkg.
module ltc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ltc_pkg::t_in_item i_item,
    output ltc_pkg::t_result  o_result
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_GLYPH,
        PH_WORD,
        PH_DONE
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [3:0]                      r_pos, n_pos;
    logic [ltc_pkg::NUM_GLYPHS-1:0]  r_glyph_mask, n_glyph_mask;
    logic [ltc_pkg::NUM_WORDS-1:0]   r_word_mask, n_word_mask;

    logic [7:0]                      lower_byte;
    logic [ltc_pkg::NUM_GLYPHS-1:0]  glyph_live, glyph_done;
    logic [ltc_pkg::NUM_WORDS-1:0]   word_live, word_close;
    logic [2:0]                      glyph_class, word_class, cls;
    logic                            found;

    assign lower_byte = ltc_pkg::to_lower(i_item.text_byte);

    always_comb begin
        glyph_class = ltc_pkg::CLS_IN_PROGRESS;
        for (int i = ltc_pkg::NUM_GLYPHS - 1; i >= 0; i--) begin
            glyph_live[i] = r_glyph_mask[i] && (r_pos < ltc_pkg::GLYPH_LEN[i]) &&
                (i_item.text_byte == ltc_pkg::glyph_char(ltc_pkg::GLYPH_TEXT[i], r_pos));
            glyph_done[i] = glyph_live[i] && (r_pos + 4'd1 == ltc_pkg::GLYPH_LEN[i]);
            if (glyph_done[i]) begin
                glyph_class = ltc_pkg::GLYPH_CLASS[i];
            end
        end
    end

    // A word closes when the bracket comes exactly one place after its last letter.
    always_comb begin
        word_class = ltc_pkg::CLS_IN_PROGRESS;
        for (int i = ltc_pkg::NUM_WORDS - 1; i >= 0; i--) begin
            word_live[i] = r_word_mask[i] && (r_pos < ltc_pkg::WORD_LEN[i]) &&
                (lower_byte == ltc_pkg::word_char(ltc_pkg::WORD_TEXT[i], r_pos));
            word_close[i] = r_word_mask[i] && (r_pos == ltc_pkg::WORD_LEN[i]) &&
                (i_item.text_byte == ltc_pkg::CH_CLOSE);
            if (word_close[i]) begin
                word_class = ltc_pkg::WORD_CLASS[i];
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_glyph_mask = r_glyph_mask;
        n_word_mask  = r_word_mask;
        found        = 1'b0;
        cls          = ltc_pkg::CLS_IN_PROGRESS;

        unique case (r_phase)
            PH_SKIP: begin
                case (i_item.text_byte) inside
                    ltc_pkg::CH_SPACE, ltc_pkg::CH_TAB, ltc_pkg::CH_LF, ltc_pkg::CH_CR: ;
                    ltc_pkg::LEAD_FOUR: begin
                        n_glyph_mask = ltc_pkg::GLYPHS_FOUR;
                        n_pos        = 4'd1;
                        n_phase      = PH_GLYPH;
                    end
                    ltc_pkg::LEAD_THREE: begin
                        n_glyph_mask = ltc_pkg::GLYPHS_THREE;
                        n_pos        = 4'd1;
                        n_phase      = PH_GLYPH;
                    end
                    ltc_pkg::CH_OPEN: begin
                        n_word_mask = '1;
                        n_pos       = 4'd0;
                        n_phase     = PH_WORD;
                    end
                    default: found = 1'b1;
                endcase
            end
            PH_GLYPH: begin
                n_glyph_mask = glyph_live;
                n_pos        = r_pos + 4'd1;
                if (|glyph_done) begin
                    found = 1'b1;
                    cls   = glyph_class;
                end else if (glyph_live == '0) begin
                    found = 1'b1;
                end
            end
            PH_WORD: begin
                n_word_mask = word_live;
                n_pos       = r_pos + 4'd1;
                if (|word_close) begin
                    found = 1'b1;
                    cls   = word_class;
                end else if (word_live == '0) begin
                    found = 1'b1;
                end
            end
            PH_DONE: ;
        endcase

        // The last byte of a message always yields a class if none was given yet.
        if (!found && i_item.end_of_text && r_phase != PH_DONE) begin
            found = 1'b1;
        end
        if (found) begin
            n_phase = PH_DONE;
        end
        if (i_item.end_of_text) begin
            n_phase      = PH_SKIP;
            n_pos        = 4'd0;
            n_glyph_mask = '1;
            n_word_mask  = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SKIP;
            r_pos        <= 4'd0;
            r_glyph_mask <= '1;
            r_word_mask  <= '1;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_glyph_mask <= n_glyph_mask;
            r_word_mask  <= n_word_mask;
        end
    end

    assign o_result.valid            = i_accept && found;
    assign o_result.item.class_code  = cls;
    assign o_result.item.settled     = (cls == ltc_pkg::CLS_VERDICT) ||
                                       (cls == ltc_pkg::CLS_HAZARD);

    a_one_per_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> r_phase != PH_DONE)
        else $error("second result within one message");

    a_clear_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.end_of_text |=> r_phase == PH_SKIP && r_pos == 4'd0)
        else $error("state not cleared after the last byte");

    a_class_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.item.class_code != ltc_pkg::CLS_IN_PROGRESS |->
            r_phase == PH_GLYPH || r_phase == PH_WORD)
        else $error("class given outside a glyph or word match");

endmodule

>>> hdl/ltc_out_reg.sv
// Output register of the leading tag classifier: holds one result until the
// receiver takes it. Depends on ltc_pkg.
module ltc_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ltc_pkg::t_result   i_result,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output ltc_pkg::t_out_item o_item
);

    logic               r_valid;
    ltc_pkg::t_out_item r_item;

    // The register may be refilled in the same cycle that its transaction completes.
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_item <= i_result.item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result.valid |-> o_can_load)
        else $error("result loaded over one still waiting");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_item))
        else $error("stalled result changed");

endmodule

>>> hdl/leading_tag_classifier.sv
// Top level of the leading tag classifier: byte input channel, class output
// channel. Depends on ltc_pkg, ltc_core and ltc_out_reg.
//
// Usage: one message is sent as a run of input transactions, one byte each, the
// final byte marked with end_of_text. Leading space, tab, CR and LF are skipped;
// the first other byte and those after it pick the class. Each message gives
// exactly one output transaction (class_code and settled), issued as soon as the
// class is known or at the final byte at the latest; later bytes are taken and
// dropped until end_of_text clears the message state.
// Throughput: one byte per cycle while not stalled. Each byte is matched against
// all glyph and word candidates in parallel by combinational compare logic.
// Output: the result is loaded into the output register at the clock edge that
// accepts the byte that decides it.
// Reset: synchronous, active low; the block starts skipping whitespace with
// every candidate live and the output register empty.
// Stalls: while a result waits and the receiver holds ready low, input ready
// drops; it rises again in the cycle the result is taken.
module leading_tag_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ltc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ltc_pkg::t_out_item o_item
);

    logic             can_load;
    logic             accept;
    ltc_pkg::t_result result;

    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    ltc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_result (result)
    );

    ltc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

>>> verif/tb.sv
// Testbench for leading_tag_classifier: directed byte table, then random messages;
// typed rows or a local classifier model check each result. Depends on ltc_pkg and RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {SKIP_WS, IN_GLYPH, IN_WORD, CLASS_GIVEN} t_scan_phase;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       eot;
        logic       typed;
        logic       typed_has;
        logic [2:0] typed_cls;
        logic       typed_settled;
    } t_stim_row;

    localparam int NUM_DIRECTED = 24;
    localparam int RANDOM_ITEMS = 1400;

    localparam logic [31:0] TAG_GLYPHS [5] = '{
        32'hF09F8F81, 32'hF09F948D, 32'hE296B600, 32'hE29AA000, 32'hE29D9300
    };
    localparam int TAG_GLYPH_LEN [5] = '{4, 4, 3, 3, 3};
    localparam logic [2:0] TAG_GLYPH_CLS [5] = '{
        ltc_pkg::CLS_VERDICT, ltc_pkg::CLS_IN_PROGRESS, ltc_pkg::CLS_EXECUTING,
        ltc_pkg::CLS_HAZARD, ltc_pkg::CLS_BLOCKED
    };
    localparam logic [71:0] TAG_WORDS [7] = '{
        "verdict  ", "done     ", "hazard   ", "warning  ",
        "executing", "exec     ", "blocked  "
    };
    localparam int TAG_WORD_LEN [7] = '{7, 4, 6, 7, 9, 4, 7};
    localparam logic [2:0] TAG_WORD_CLS [7] = '{
        ltc_pkg::CLS_VERDICT, ltc_pkg::CLS_VERDICT, ltc_pkg::CLS_HAZARD,
        ltc_pkg::CLS_HAZARD, ltc_pkg::CLS_EXECUTING, ltc_pkg::CLS_EXECUTING,
        ltc_pkg::CLS_BLOCKED
    };

    // Expected results are typed in only for rows whose outcome is obvious.
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h20, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h09, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h9F, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h8F, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h81, 1'b1, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h0D, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h0A, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h9D, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h93, 1'b1, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h5B, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h45, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h78, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h65, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h43, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h5D, 1'b1, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h9A, 1'b1, 1'b1, 1'b1, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h5B, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'hC3, 1'b0, 1'b0, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0},
        '{8'h78, 1'b1, 1'b1, 1'b0, ltc_pkg::CLS_IN_PROGRESS, 1'b0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    ltc_pkg::t_in_item   i_item;
    logic                o_valid;
    logic                i_ready = 1'b0;
    ltc_pkg::t_out_item  o_item;

    t_scan_phase scan_phase;
    logic [3:0]  scan_pos;
    logic [13:0] scan_mask;
    logic        scan_sent;

    ltc_pkg::t_out_item expected_tags [$];
    logic [7:0]         msg_bytes [$];
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 tx_idle_pct = 14;
    int                 rx_idle_pct = 61;

    leading_tag_classifier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic clear_scan();
        scan_phase = SKIP_WS;
        scan_pos   = 4'd0;
        scan_mask  = 14'h3FFF;
        scan_sent  = 1'b0;
    endtask

    // Advances the classifier model by one byte and says whether it yields a class.
    task automatic classify_byte(input logic [7:0] b, input logic eot,
                                 output logic has_tag, output ltc_pkg::t_out_item tag);
        logic [2:0] cls;
        logic [7:0] lb;
        int         p;
        has_tag = 1'b0;
        cls     = ltc_pkg::CLS_IN_PROGRESS;
        p       = scan_pos;
        lb      = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
        if (!scan_sent) begin
            case (scan_phase)
                SKIP_WS: begin
                    if (b == ltc_pkg::CH_SPACE || b == ltc_pkg::CH_TAB ||
                        b == ltc_pkg::CH_LF || b == ltc_pkg::CH_CR) begin
                    end else if (b == ltc_pkg::LEAD_FOUR) begin
                        scan_mask  = 14'h0003;
                        scan_pos   = 4'd1;
                        scan_phase = IN_GLYPH;
                    end else if (b == ltc_pkg::LEAD_THREE) begin
                        scan_mask  = 14'h001C;
                        scan_pos   = 4'd1;
                        scan_phase = IN_GLYPH;
                    end else if (b == ltc_pkg::CH_OPEN) begin
                        scan_mask  = 14'h0FE0;
                        scan_pos   = 4'd0;
                        scan_phase = IN_WORD;
                    end else begin
                        has_tag = 1'b1;
                    end
                end
                IN_GLYPH: begin
                    for (int g = 0; g < 5; g++) begin
                        if (scan_mask[g]) begin
                            if (p < TAG_GLYPH_LEN[g] && b == TAG_GLYPHS[g][31-8*p -: 8]) begin
                                if (p + 1 == TAG_GLYPH_LEN[g] && !has_tag) begin
                                    has_tag = 1'b1;
                                    cls     = TAG_GLYPH_CLS[g];
                                end
                            end else begin
                                scan_mask[g] = 1'b0;
                            end
                        end
                    end
                    if (!has_tag && scan_mask[4:0] == 5'd0) has_tag = 1'b1;
                    scan_pos = scan_pos + 4'd1;
                end
                IN_WORD: begin
                    for (int w = 0; w < 7; w++) begin
                        if (scan_mask[w+5]) begin
                            if (p < TAG_WORD_LEN[w] && lb == TAG_WORDS[w][71-8*p -: 8]) begin
                            end else if (p == TAG_WORD_LEN[w] && b == ltc_pkg::CH_CLOSE) begin
                                if (!has_tag) begin
                                    has_tag = 1'b1;
                                    cls     = TAG_WORD_CLS[w];
                                end
                            end else begin
                                scan_mask[w+5] = 1'b0;
                            end
                        end
                    end
                    if (!has_tag && scan_mask[11:5] == 7'd0) has_tag = 1'b1;
                    scan_pos = scan_pos + 4'd1;
                end
                default: begin
                end
            endcase
            if (!has_tag && eot) has_tag = 1'b1;
        end
        if (has_tag) begin
            scan_sent  = 1'b1;
            scan_phase = CLASS_GIVEN;
        end
        tag.class_code = cls;
        tag.settled    = (cls == ltc_pkg::CLS_VERDICT || cls == ltc_pkg::CLS_HAZARD);
        if (eot) clear_scan();
    endtask

    // Entered just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge.
    task automatic send_byte(input t_stim_row row);
        logic               has_tag;
        ltc_pkg::t_out_item tag;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{text_byte: row.text_byte, end_of_text: row.eot};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        classify_byte(row.text_byte, row.eot, has_tag, tag);
        if (row.typed) begin
            has_tag = row.typed_has;
            tag     = '{class_code: row.typed_cls, settled: row.typed_settled};
        end
        if (has_tag) expected_tags.push_back(tag);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Mostly well-formed tags with random case, whitespace and tails; some corrupted,
    // cut short or pure noise.
    task automatic build_message();
        int         kind;
        int         sel;
        int         len;
        logic [7:0] ch;
        msg_bytes.delete();
        repeat ($urandom_range(3)) begin
            case ($urandom_range(3))
                0:       msg_bytes.push_back(ltc_pkg::CH_SPACE);
                1:       msg_bytes.push_back(ltc_pkg::CH_TAB);
                2:       msg_bytes.push_back(ltc_pkg::CH_LF);
                default: msg_bytes.push_back(ltc_pkg::CH_CR);
            endcase
        end
        kind = $urandom_range(99);
        if (kind < 35) begin
            sel = $urandom_range(4);
            for (int k = 0; k < TAG_GLYPH_LEN[sel]; k++)
                msg_bytes.push_back(TAG_GLYPHS[sel][31-8*k -: 8]);
        end else if (kind < 85) begin
            sel = $urandom_range(6);
            len = (kind < 75) ? TAG_WORD_LEN[sel] : $urandom_range(TAG_WORD_LEN[sel]);
            msg_bytes.push_back(ltc_pkg::CH_OPEN);
            for (int k = 0; k < len; k++) begin
                ch = TAG_WORDS[sel][71-8*k -: 8];
                if ($urandom_range(1)) ch = ch - 8'd32;
                msg_bytes.push_back(ch);
            end
            msg_bytes.push_back(ltc_pkg::CH_CLOSE);
        end else begin
            repeat ($urandom_range(6, 1)) msg_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(9) == 0)
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom);
        if ($urandom_range(9) == 0 && msg_bytes.size() > 1) begin
            len = $urandom_range(msg_bytes.size() - 1, 1);
            while (msg_bytes.size() > len) void'(msg_bytes.pop_back());
        end
        repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
    endtask

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10) $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        ltc_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tags.size() == 0) begin
                note_mismatch($sformatf("unexpected result class %0d settled %0b",
                                        o_item.class_code, o_item.settled));
            end else begin
                want = expected_tags.pop_front();
                if (o_item.class_code !== want.class_code || o_item.settled !== want.settled)
                    note_mismatch($sformatf("expected class %0d settled %0b, got %0d %0b",
                                            want.class_code, want.settled,
                                            o_item.class_code, o_item.settled));
            end
        end
    end

    initial begin
        t_stim_row row;
        clear_scan();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < NUM_DIRECTED; k++) send_byte(DIRECTED[k]);
        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
            if (items_sent < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 14;
                rx_idle_pct = 61;
            end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 61;
                rx_idle_pct = 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            build_message();
            for (int n = 0; n < msg_bytes.size(); n++) begin
                row = '{msg_bytes[n], (n == msg_bytes.size() - 1), 1'b0, 1'b0,
                        ltc_pkg::CLS_IN_PROGRESS, 1'b0};
                send_byte(row);
            end
        end
        i_valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge i_clk);
        // Run on so that any stray result still shows up.
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_tags.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
